// ===== design/hmm_viterbi_decode_assert.svh =====
// Assertion macros shared by the Viterbi decoder RTL.
`ifndef HMM_VITERBI_DECODE_ASSERT_SVH
`define HMM_VITERBI_DECODE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HVD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HVD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hvd_pkg.sv =====
// Types and cost helpers shared by the Viterbi decoder modules.
package hvd_pkg;

  localparam int unsigned MetricW = 16;
  localparam int unsigned CostW   = 8;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last;
  } hvd_item_t;

  typedef struct packed {
    logic tracing;
    logic emitting;
  } hvd_status_t;

  function automatic logic [CostW-1:0] emit_cost(input logic [3*CostW-1:0] costs,
                                                input logic [1:0] sym);
    logic [CostW-1:0] c;
    case (sym)
      2'd0: c = costs[CostW-1:0];
      2'd1: c = costs[2*CostW-1:CostW];
      2'd2: c = costs[3*CostW-1:2*CostW];
      default: c = {CostW{1'b1}};
    endcase
    return c;
  endfunction

  function automatic logic [MetricW-1:0] sat_metric(input logic [MetricW:0] v);
    return v[MetricW] ? {MetricW{1'b1}} : v[MetricW-1:0];
  endfunction

endpackage

// ===== design/hvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hvd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hvd_front.sv =====
// Input side: accepts symbols, marks sequence ends and queues items for the back end.
module hvd_front import hvd_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  logic [1:0] symbol_i,
  input  logic      end_of_sequence_i,
  output hvd_item_t item_o,
  output logic      valid_o,
  input  logic      ready_i
);

  localparam int unsigned AW = $clog2(MAX_SEQ_LEN);

  logic [AW-1:0] step_q, step_d;
  hvd_item_t     ent_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          acc;
  logic          take;
  hvd_item_t     in_item;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rptr_q];
  assign acc     = push_i & ~full_o;
  assign take    = valid_o & ready_i;

  always_comb begin
    in_item.symbol = symbol_i;
    in_item.last   = end_of_sequence_i | (step_q == AW'(MAX_SEQ_LEN - 1));
    step_d = step_q;
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (acc) begin
      step_d = in_item.last ? '0 : step_q + 1'b1;
      wptr_d = ~wptr_q;
    end
    if (take) begin
      rptr_d = ~rptr_q;
    end
    case ({acc, take})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q[wptr_q] <= in_item;
    end
  end

endmodule

// ===== design/hvd_back.sv =====
// Back end: add-compare-select per item, traceback and in-order emission of decoded states.
module hvd_back import hvd_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hvd_item_t   item_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] start_costs_i,
  input  logic [31:0] trans_costs_i,
  input  logic [23:0] emit0_i,
  input  logic [23:0] emit1_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        decoded_state_o,
  output logic        last_state_o,
  output hvd_status_t status_o
);

  localparam int unsigned AW = $clog2(MAX_SEQ_LEN);

  typedef enum logic [1:0] {
    ST_ACS,
    ST_TRACE,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [MetricW-1:0]  pm0_q, pm0_d, pm1_q, pm1_d;
  logic [AW-1:0]       t_q, t_d;
  logic [AW-1:0]       p_q, p_d;
  logic [AW-1:0]       lidx_q, lidx_d;
  logic [AW-1:0]       e_q, e_d;
  logic [AW-1:0]       pidx_q, pidx_d;
  logic                cur_q, cur_d;
  logic                use_reg_q, use_reg_d;
  logic [1:0]          bits_q, bits_d;
  logic                iss_done_q, iss_done_d;
  logic                pend_q, pend_d;
  logic                ovalid_q, ovalid_d;
  logic                odec_q, odec_d;
  logic                olast_q, olast_d;

  logic                take;
  logic [CostW-1:0]    e0, e1;
  logic [MetricW:0]    c00, c10, c01, c11;
  logic                b0, b1;
  logic [MetricW-1:0]  n0, n1;
  logic [1:0]          bits;
  logic                end_cur;
  logic [1:0]          surv_rdata;
  logic [1:0]          sbits;
  logic                trace_cur;
  logic                dec_rdata;
  logic                surv_re;
  logic                dec_we;
  logic [AW-1:0]       dec_waddr;
  logic                dec_wdata;
  logic                out_free;
  logic                load;
  logic                issue;

  assign ready_o = (state_q == ST_ACS);
  assign take    = valid_i & ready_o;

  always_comb begin
    e0  = emit_cost(emit0_i, item_i.symbol);
    e1  = emit_cost(emit1_i, item_i.symbol);
    c00 = {1'b0, pm0_q} + {{(MetricW+1-CostW){1'b0}}, trans_costs_i[7:0]};
    c01 = {1'b0, pm0_q} + {{(MetricW+1-CostW){1'b0}}, trans_costs_i[15:8]};
    c10 = {1'b0, pm1_q} + {{(MetricW+1-CostW){1'b0}}, trans_costs_i[23:16]};
    c11 = {1'b0, pm1_q} + {{(MetricW+1-CostW){1'b0}}, trans_costs_i[31:24]};
    b0  = (c10 < c00);
    b1  = (c11 < c01);
    if (t_q == '0) begin
      bits = 2'b00;
      n0 = MetricW'({1'b0, start_costs_i[7:0]} + {1'b0, e0});
      n1 = MetricW'({1'b0, start_costs_i[15:8]} + {1'b0, e1});
    end else begin
      bits = {b1, b0};
      n0 = sat_metric({1'b0, sat_metric(b0 ? c10 : c00)}
                      + {{(MetricW+1-CostW){1'b0}}, e0});
      n1 = sat_metric({1'b0, sat_metric(b1 ? c11 : c01)}
                      + {{(MetricW+1-CostW){1'b0}}, e1});
    end
    end_cur = (n1 < n0);
  end

  assign sbits     = use_reg_q ? bits_q : surv_rdata;
  assign trace_cur = sbits[cur_q];
  assign surv_re   = (state_q == ST_TRACE);

  always_comb begin
    dec_we    = 1'b0;
    dec_waddr = t_q;
    dec_wdata = end_cur;
    if (state_q == ST_TRACE) begin
      dec_we    = 1'b1;
      dec_waddr = p_q - 1'b1;
      dec_wdata = trace_cur;
    end else if (take && item_i.last) begin
      dec_we = 1'b1;
    end
  end

  assign out_free = ~ovalid_q | pop_i;
  assign load     = (state_q == ST_EMIT) & pend_q & out_free;
  assign issue    = (state_q == ST_EMIT) & ~iss_done_q & (~pend_q | out_free);

  always_comb begin
    state_d    = state_q;
    pm0_d      = pm0_q;
    pm1_d      = pm1_q;
    t_d        = t_q;
    p_d        = p_q;
    lidx_d     = lidx_q;
    e_d        = e_q;
    pidx_d     = pidx_q;
    cur_d      = cur_q;
    use_reg_d  = use_reg_q;
    bits_d     = bits_q;
    iss_done_d = iss_done_q;
    pend_d     = pend_q;
    ovalid_d   = ovalid_q & ~pop_i;
    odec_d     = odec_q;
    olast_d    = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      odec_d   = dec_rdata;
      olast_d  = (pidx_q == lidx_q);
    end
    case (state_q)
      ST_ACS: begin
        if (take) begin
          if (item_i.last) begin
            lidx_d     = t_q;
            t_d        = '0;
            pm0_d      = '0;
            pm1_d      = '0;
            cur_d      = end_cur;
            bits_d     = bits;
            p_d        = t_q;
            use_reg_d  = 1'b1;
            e_d        = '0;
            iss_done_d = 1'b0;
            pend_d     = 1'b0;
            state_d    = (t_q == '0) ? ST_EMIT : ST_TRACE;
          end else begin
            t_d   = t_q + 1'b1;
            pm0_d = n0;
            pm1_d = n1;
          end
        end
      end
      ST_TRACE: begin
        cur_d     = trace_cur;
        p_d       = p_q - 1'b1;
        use_reg_d = 1'b0;
        if (p_q == AW'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          pend_d = 1'b1;
          pidx_d = e_q;
          e_d    = e_q + 1'b1;
          if (e_q == lidx_q) begin
            iss_done_d = 1'b1;
          end
        end else if (load) begin
          pend_d = 1'b0;
        end
        if (iss_done_q && !pend_q) begin
          state_d = ST_ACS;
        end
      end
      default: state_d = ST_ACS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_ACS;
      pm0_q      <= '0;
      pm1_q      <= '0;
      t_q        <= '0;
      iss_done_q <= 1'b0;
      pend_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      use_reg_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pm0_q      <= pm0_d;
      pm1_q      <= pm1_d;
      t_q        <= t_d;
      iss_done_q <= iss_done_d;
      pend_q     <= pend_d;
      ovalid_q   <= ovalid_d;
      use_reg_q  <= use_reg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    lidx_q  <= lidx_d;
    e_q     <= e_d;
    pidx_q  <= pidx_d;
    cur_q   <= cur_d;
    bits_q  <= bits_d;
    odec_q  <= odec_d;
    olast_q <= olast_d;
  end

  hvd_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SEQ_LEN)
  ) u_surv_ram (
    .clk_i   (clk_i),
    .we_i    (take),
    .waddr_i (t_q),
    .wdata_i (bits),
    .re_i    (surv_re),
    .raddr_i (p_q - 1'b1),
    .rdata_o (surv_rdata)
  );

  hvd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SEQ_LEN)
  ) u_dec_ram (
    .clk_i   (clk_i),
    .we_i    (dec_we),
    .waddr_i (dec_waddr),
    .wdata_i (dec_wdata),
    .re_i    (issue),
    .raddr_i (e_q),
    .rdata_o (dec_rdata)
  );

  assign empty_o         = ~ovalid_q;
  assign decoded_state_o = odec_q;
  assign last_state_o    = olast_q;
  assign status_o.tracing  = (state_q == ST_TRACE);
  assign status_o.emitting = (state_q == ST_EMIT);

endmodule

// ===== design/hmm_viterbi_decode.sv =====
// Top level of the two-state, three-symbol log-domain Viterbi decoder.
// Each pushed symbol gets one add-compare-select step in the back end, and a two-entry
// queue lets the input side run ahead of it. A sequence of L symbols (ending on the item
// that marks the end or on the MAX_SEQ_LEN-th item) is then traced back through the
// survivor memory, followed by an emission phase in which the decoded states are read
// from memory and popped first to last, after which the back end returns to accepting
// symbols. No new symbol enters the back end during traceback and emission.
// Configuration registers reset to zero and are written through cfg_we_i, cfg_idx_i and
// cfg_data_i, by the user only while the decoder is idle; the block does not enforce it.
module hmm_viterbi_decode import hvd_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  symbol_i,
  input  logic        end_of_sequence_i,
  output logic        empty,
  input  logic        pop,
  output logic        decoded_state_o,
  output logic        last_state_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [1:0] RegStart = 2'd0;
  localparam logic [1:0] RegTrans = 2'd1;
  localparam logic [1:0] RegEmit0 = 2'd2;
  localparam logic [1:0] RegEmit1 = 2'd3;

  logic [15:0] start_q;
  logic [31:0] trans_q;
  logic [23:0] emit0_q;
  logic [23:0] emit1_q;

  hvd_item_t   item;
  logic        item_valid;
  logic        item_ready;
  hvd_status_t status;
  logic        item_take;
  logic        busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      trans_q <= '0;
      emit0_q <= '0;
      emit1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStart: start_q <= cfg_data_i[15:0];
        RegTrans: trans_q <= cfg_data_i;
        RegEmit0: emit0_q <= cfg_data_i[23:0];
        RegEmit1: emit1_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  hvd_front #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .symbol_i          (symbol_i),
    .end_of_sequence_i (end_of_sequence_i),
    .item_o            (item),
    .valid_o           (item_valid),
    .ready_i           (item_ready)
  );

  hvd_back #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .valid_i         (item_valid),
    .ready_o         (item_ready),
    .start_costs_i   (start_q),
    .trans_costs_i   (trans_q),
    .emit0_i         (emit0_q),
    .emit1_i         (emit1_q),
    .empty_o         (empty),
    .pop_i           (pop),
    .decoded_state_o (decoded_state_o),
    .last_state_o    (last_state_o),
    .status_o        (status)
  );

  assign item_take = item_valid & item_ready;
  assign busy      = status.tracing | status.emitting;

`include "hmm_viterbi_decode_assert.svh"

  `HVD_ASSERT_IMP(a_phase_excl, 1'b1, !(status.tracing && status.emitting), "trace and emit overlap")
  `HVD_ASSERT_IMP(a_no_take_busy, item_take, !busy, "item taken while busy")
  `HVD_ASSERT_NXT(a_end_starts_tb, item_take && item.last, busy, "sequence end not decoded")

endmodule
